[rtl/dgrad_pkg.sv]
// Shared types and constants for the dithered linear gradient pixel block.
package dgrad_pkg;

    localparam int COORD_BITS  = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int COLOR_W     = 24;

    // Block index by reciprocal multiply: exact for any 4-bit step and coords up to 14 bits.
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam int LUMA_R      = 299;
    localparam int LUMA_G      = 587;
    localparam int LUMA_B      = 114;
    localparam int LUMA_DIV    = 1000;
    localparam int MONO_LEVEL  = 127;
    localparam int MONO_SUM    = (MONO_LEVEL + 1) * LUMA_DIV;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_DIR_X        = 3'd2,
        CFG_DIR_Y        = 3'd3,
        CFG_PROJ_SCALE   = 3'd4,
        CFG_START_COLOR  = 3'd5,
        CFG_END_COLOR    = 3'd6,
        CFG_BLOCK_STEP   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       mono_white;
    } t_pix_out;

    // ceil(2^RECIP_SHIFT / step); a step of zero counts as one.
    function automatic logic [RECIP_W-1:0] recip_step(input logic [3:0] step);
        logic [RECIP_W-1:0] r;
        unique case (step)
            4'd0:    r = 19'd262144;
            4'd1:    r = 19'd262144;
            4'd2:    r = 19'd131072;
            4'd3:    r = 19'd87382;
            4'd4:    r = 19'd65536;
            4'd5:    r = 19'd52429;
            4'd6:    r = 19'd43691;
            4'd7:    r = 19'd37450;
            4'd8:    r = 19'd32768;
            4'd9:    r = 19'd29128;
            4'd10:   r = 19'd26215;
            4'd11:   r = 19'd23832;
            4'd12:   r = 19'd21846;
            4'd13:   r = 19'd20165;
            4'd14:   r = 19'd18725;
            default: r = 19'd17477;
        endcase
        return r;
    endfunction

endpackage

[rtl/dgrad_color.sv]
// Per-channel lerp between the two colors plus the luminance threshold bit.
module dgrad_color #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [FRAC_BITS:0]                i_t,
    input  logic [dgrad_pkg::COLOR_W-1:0]     i_start_color,
    input  logic [dgrad_pkg::COLOR_W-1:0]     i_end_color,
    output logic                              o_done,
    output dgrad_pkg::t_pix_out               o_result
);
    import dgrad_pkg::*;

    localparam int TW   = FRAC_BITS + 1;
    localparam int PRW  = TW + 8;
    localparam int SUMW = PRW + 1;
    localparam int LW   = 18;
    localparam logic [TW-1:0]   ONE_T  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [SUMW-1:0] HALF_S = SUMW'(1) << (FRAC_BITS - 1);

    logic             r_v1, r_v2, r_v3;
    logic [PRW-1:0]   r_ps [3];
    logic [PRW-1:0]   r_pe [3];
    logic [7:0]       r_ch [3];
    logic [PRW-1:0]   n_ps [3];
    logic [PRW-1:0]   n_pe [3];
    logic [7:0]       n_ch [3];
    logic [SUMW-1:0]  sum  [3];
    logic [LW-1:0]    lum;
    t_pix_out         r_out;
    t_pix_out         n_out;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_ps[c] = PRW'(i_start_color[8*(2-c) +: 8]) * PRW'(ONE_T - i_t);
            n_pe[c] = PRW'(i_end_color[8*(2-c) +: 8]) * PRW'(i_t);
            sum[c]  = SUMW'(r_ps[c]) + SUMW'(r_pe[c]) + HALF_S;
            n_ch[c] = sum[c][FRAC_BITS +: 8];
        end
    end

    // 299r + 587g + 114b >= 128000 is the same as the integer mean exceeding 127
    assign lum = LW'(r_ch[0]) * LW'(LUMA_R) + LW'(r_ch[1]) * LW'(LUMA_G)
               + LW'(r_ch[2]) * LW'(LUMA_B);

    always_comb begin
        n_out.red        = r_ch[0];
        n_out.green      = r_ch[1];
        n_out.blue       = r_ch[2];
        n_out.mono_white = (lum >= LW'(MONO_SUM));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ps  <= n_ps;
        r_pe  <= n_pe;
        r_ch  <= n_ch;
        r_out <= n_out;
    end

    assign o_done   = r_v3;
    assign o_result = r_out;

endmodule

[rtl/dithered_linear_gradient_pixel.sv]
// Top level: projection onto the gradient direction, clamp, ordered dither, color lerp.
// o_done rises for an accepted start once the item has passed the nine register stages.
// Throughput: one item per cycle; busy never rises, nothing in the pipe can stall.
// The pipeline is nine register stages; the projection scale multiply is split in halves.
// Reset (synchronous, i_rst_n low) empties the pipeline and loads the register defaults.
// Results are strobed on o_done for one cycle and cannot be held off.
module dithered_linear_gradient_pixel #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  dgrad_pkg::t_pix_in                  i_pixel,
    output logic                                o_done,
    output dgrad_pkg::t_pix_out                 o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dgrad_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dgrad_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import dgrad_pkg::*;

    localparam int DW  = ((COORD_BITS + 1 > 11) ? COORD_BITS + 1 : 11) + 1;
    localparam int PW  = DW + 18;
    localparam int SW  = PW + 1;
    localparam int LW  = SW + 13;
    localparam int RW  = SW + 25;
    localparam int TW  = FRAC_BITS + 1;
    localparam int QW  = COORD_BITS + RECIP_W;
    localparam int ONE = 1 << FRAC_BITS;
    localparam int D1  = (ONE + 50) / 100;
    localparam int D3  = (3 * ONE + 50) / 100;
    localparam int LAT = 9;
    localparam logic signed [RW-1:0] HALF_W = RW'(ONE / 2);
    localparam logic [TW-1:0]        ONE_T  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [TW:0]   DITHER [4] = '{-(TW+1)'(D3), -(TW+1)'(D1),
                                                    (TW+1)'(D1), (TW+1)'(D3)};

    // configuration registers
    logic [10:0]         r_frame_width;
    logic [10:0]         r_frame_height;
    logic signed [17:0]  r_dir_x;
    logic signed [17:0]  r_dir_y;
    logic [23:0]         r_scale;
    logic [23:0]         r_start_color;
    logic [23:0]         r_end_color;
    logic [3:0]          r_block_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 11'd144;
            r_frame_height <= 11'd168;
            r_dir_x        <= 18'sd0;
            r_dir_y        <= -18'sd65536;
            r_scale        <= 24'd512;
            r_start_color  <= 24'd0;
            r_end_color    <= 24'd0;
            r_block_step   <= 4'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[10:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[10:0];
                CFG_DIR_X:        r_dir_x        <= $signed(i_cfg_data[17:0]);
                CFG_DIR_Y:        r_dir_y        <= $signed(i_cfg_data[17:0]);
                CFG_PROJ_SCALE:   r_scale        <= i_cfg_data[23:0];
                CFG_START_COLOR:  r_start_color  <= i_cfg_data[23:0];
                CFG_END_COLOR:    r_end_color    <= i_cfg_data[23:0];
                CFG_BLOCK_STEP:   r_block_step   <= i_cfg_data[3:0];
                default:          r_block_step   <= r_block_step;
            endcase
        end
    end

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // stage 1: doubled center offsets times direction, block index quotients
    logic signed [DW-1:0] dx2, dy2;
    logic [RECIP_W-1:0]   recip;
    logic [QW-1:0]        qx_full, qy_full;
    logic                 r_v1;
    logic signed [PW-1:0] r_px, r_py;
    logic [1:0]           r_qx, r_qy;

    assign dx2     = $signed(DW'({i_pixel.pixel_x, 1'b0})) - $signed(DW'(r_frame_width));
    assign dy2     = $signed(DW'({i_pixel.pixel_y, 1'b0})) - $signed(DW'(r_frame_height));
    assign recip   = recip_step(r_block_step);
    assign qx_full = QW'(i_pixel.pixel_x) * QW'(recip);
    assign qy_full = QW'(i_pixel.pixel_y) * QW'(recip);

    // stage 2: dot product, dither phase ((13*bx + 17*by) mod 4 == (bx + by) mod 4)
    logic                 r_v2;
    logic signed [SW-1:0] r_sum;
    logic [1:0]           r_pat2;

    // stage 3: dot product times scale, in two halves
    logic                 r_v3;
    logic signed [LW-1:0] r_plo, r_phi;
    logic [1:0]           r_pat3;

    // stage 4: recombined raw product
    logic                 r_v4;
    logic signed [RW-1:0] r_raw;
    logic [1:0]           r_pat4;

    // stage 5: factor before dither
    logic signed [RW-1:0] sh;
    logic [TW-1:0]        n_t1;
    logic                 r_v5;
    logic [TW-1:0]        r_t1;
    logic [1:0]           r_pat5;

    // stage 6: dithered factor
    logic signed [TW:0]   td;
    logic [TW-1:0]        n_t;
    logic                 r_v6;
    logic [TW-1:0]        r_t;

    // floor shift works for both signs: the arithmetic shift rounds toward minus infinity
    assign sh = r_raw >>> (FRAC_BITS + 1);

    always_comb begin
        priority if (sh > HALF_W) begin
            n_t1 = ONE_T;
        end else if (sh < -HALF_W) begin
            n_t1 = '0;
        end else begin
            n_t1 = TW'(sh + HALF_W);
        end
    end

    assign td = $signed({1'b0, r_t1}) + DITHER[r_pat5];

    always_comb begin
        priority if (td < 0) begin
            n_t = '0;
        end else if (td > $signed({1'b0, ONE_T})) begin
            n_t = ONE_T;
        end else begin
            n_t = TW'(td);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px   <= PW'(dx2) * PW'(r_dir_x);
        r_py   <= PW'(dy2) * PW'(r_dir_y);
        r_qx   <= qx_full[RECIP_SHIFT +: 2];
        r_qy   <= qy_full[RECIP_SHIFT +: 2];
        r_sum  <= SW'(r_px) + SW'(r_py);
        r_pat2 <= r_qx + r_qy;
        r_plo  <= LW'(r_sum) * LW'($signed({1'b0, r_scale[11:0]}));
        r_phi  <= LW'(r_sum) * LW'($signed({1'b0, r_scale[23:12]}));
        r_pat3 <= r_pat2;
        r_raw  <= (RW'(r_phi) <<< 12) + RW'(r_plo);
        r_pat4 <= r_pat3;
        r_t1   <= n_t1;
        r_pat5 <= r_pat4;
        r_t    <= n_t;
    end

    dgrad_color #(
        .FRAC_BITS(FRAC_BITS)
    ) u_color (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_v6),
        .i_t           (r_t),
        .i_start_color (r_start_color),
        .i_end_color   (r_end_color),
        .o_done        (o_done),
        .o_result      (o_result)
    );

    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_done)
        else $error("accepted item produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##LAT !o_done)
        else $error("result without an accepted item");

    a_t_pre_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (r_t1 <= ONE_T))
        else $error("undithered factor above one");

    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v6 |-> (r_t <= ONE_T))
        else $error("dithered factor above one");

endmodule

[verif/tb_dithered_linear_gradient_pixel.sv]
// Testbench for the dithered linear gradient pixel block: directed and random items.
`timescale 1ns / 100ps

module tb_dithered_linear_gradient_pixel;
    import dgrad_pkg::*;

    localparam int     FRAC_BITS = 16;
    localparam longint ONE       = longint'(1) << FRAC_BITS;
    localparam longint HALF      = longint'(1) << (FRAC_BITS - 1);
    localparam longint D1        = (ONE + 50) / 100;
    localparam longint D3        = (3 * ONE + 50) / 100;
    // dither offset per phase (13*bx + 17*by) & 3
    localparam longint DITHER_OFS [4] = '{-D3, -D1, D1, D3};

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_pix_in               i_pixel     = '0;
    logic                  o_done;
    t_pix_out              o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // gradient settings as the block should hold them (reset values)
    logic [10:0]        grad_width  = 11'd144;
    logic [10:0]        grad_height = 11'd168;
    logic signed [17:0] grad_dir_x  = 18'sd0;
    logic signed [17:0] grad_dir_y  = -18'sd65536;
    logic [23:0]        grad_scale  = 24'd512;
    logic [23:0]        grad_start  = 24'd0;
    logic [23:0]        grad_end    = 24'd0;
    logic [3:0]         grad_step   = 4'd2;

    logic [23:0] cfg_plan [8];
    t_pix_out    pixel_want_q [$];
    int          mismatch_count = 0;
    int          burst_left     = 0;

    dithered_linear_gradient_pixel #(.FRAC_BITS(FRAC_BITS)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_pixel     (i_pixel),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void store_reg(input t_cfg_idx idx, input logic [23:0] data);
        case (idx)
            CFG_FRAME_WIDTH:  grad_width  = data[10:0];
            CFG_FRAME_HEIGHT: grad_height = data[10:0];
            CFG_DIR_X:        grad_dir_x  = data[17:0];
            CFG_DIR_Y:        grad_dir_y  = data[17:0];
            CFG_PROJ_SCALE:   grad_scale  = data;
            CFG_START_COLOR:  grad_start  = data;
            CFG_END_COLOR:    grad_end    = data;
            CFG_BLOCK_STEP:   grad_step   = data[3:0];
            default: ;
        endcase
    endfunction

    function automatic longint clamp_unit(input longint t);
        if (t < 0)
            return 0;
        if (t > ONE)
            return ONE;
        return t;
    endfunction

    function automatic logic [7:0] blend_channel(input logic [7:0] c0, input logic [7:0] c1,
                                                 input longint t);
        longint v;
        v = longint'(c0) * (ONE - t) + longint'(c1) * t + HALF;
        return 8'(v >>> FRAC_BITS);
    endfunction

    function automatic t_pix_out predict_pixel(input t_pix_in pin);
        longint      dx2, dy2, raw, t;
        int unsigned stp, bx, by, lum;
        t_pix_out    res;
        // offsets from the centre are doubled so half pixels stay exact
        dx2 = 2 * longint'(pin.pixel_x) - longint'(grad_width);
        dy2 = 2 * longint'(pin.pixel_y) - longint'(grad_height);
        raw = (dx2 * longint'(grad_dir_x) + dy2 * longint'(grad_dir_y)) * longint'(grad_scale);
        t   = clamp_unit(HALF + (raw >>> (FRAC_BITS + 1)));
        stp = (grad_step == 4'd0) ? 1 : int'(grad_step);
        bx  = int'(pin.pixel_x) / stp;
        by  = int'(pin.pixel_y) / stp;
        t   = clamp_unit(t + DITHER_OFS[(13 * bx + 17 * by) & 3]);
        res.red   = blend_channel(grad_start[23:16], grad_end[23:16], t);
        res.green = blend_channel(grad_start[15:8], grad_end[15:8], t);
        res.blue  = blend_channel(grad_start[7:0], grad_end[7:0], t);
        lum = (int'(res.red) * LUMA_R + int'(res.green) * LUMA_G + int'(res.blue) * LUMA_B)
              / LUMA_DIV;
        res.mono_white = (lum > MONO_LEVEL);
        return res;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_pix_out want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pixel_want_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with no item outstanding: %h %h %h %b", $time,
                             o_result.red, o_result.green, o_result.blue, o_result.mono_white);
            end else begin
                want = pixel_want_q.pop_front();
                if (o_result.red !== want.red || o_result.green !== want.green ||
                    o_result.blue !== want.blue || o_result.mono_white !== want.mono_white) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: rgb/mono expected %h %h %h %b, got %h %h %h %b", $time,
                                 want.red, want.green, want.blue, want.mono_white,
                                 o_result.red, o_result.green, o_result.blue,
                                 o_result.mono_white);
                end
            end
        end
    end

    // writes all registers back to back from cfg_plan; valid stays high across the writes
    task automatic apply_cfg();
        for (int i = 0; i < 8; i++) begin
            i_cfg_index <= t_cfg_idx'(i);
            i_cfg_data  <= cfg_plan[i];
            i_cfg_valid <= 1'b1;
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            store_reg(t_cfg_idx'(i), cfg_plan[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_gradient(input logic [23:0] w, input logic [23:0] h,
                                input logic [23:0] dx, input logic [23:0] dy,
                                input logic [23:0] sc, input logic [23:0] c0,
                                input logic [23:0] c1, input logic [23:0] stp);
        cfg_plan[CFG_FRAME_WIDTH]  = w;
        cfg_plan[CFG_FRAME_HEIGHT] = h;
        cfg_plan[CFG_DIR_X]        = dx;
        cfg_plan[CFG_DIR_Y]        = dy;
        cfg_plan[CFG_PROJ_SCALE]   = sc;
        cfg_plan[CFG_START_COLOR]  = c0;
        cfg_plan[CFG_END_COLOR]    = c1;
        cfg_plan[CFG_BLOCK_STEP]   = stp;
        apply_cfg();
    endtask

    // start stays high within a burst; a nonzero gap between bursts lowers it
    task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
        t_pix_in item;
        int      gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        item.pixel_x = px;
        item.pixel_y = py;
        i_pixel <= item;
        start   <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        pixel_want_q.push_back(predict_pixel(item));
    endtask

    // every item yields a result, so an empty queue means an empty pipeline
    task automatic wait_drain();
        start <= 1'b0;
        while (pixel_want_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd72, 10'd84);
        send_pixel(10'd1023, 10'd1023);
    endtask

    task automatic test_color_extremes();
        wait_drain();
        set_gradient(24'd144, 24'd168, 24'd0, 24'hFF0000, 24'd512,
                     24'h000000, 24'hFFFFFF, 24'd2);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'h155, 10'h2AA);
        send_pixel(10'h2AA, 10'h155);
        wait_drain();
        set_gradient(24'h0007FF, 24'd1, 24'h010000, 24'd0, 24'd64,
                     24'hFFFFFF, 24'h000000, 24'd8);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0, 10'd1023);
    endtask

    // zero scale leaves t at one half, so each dither phase shows up directly
    task automatic test_dither_and_step();
        wait_drain();
        set_gradient(24'd144, 24'd168, 24'd0, 24'hFF0000, 24'd0,
                     24'h000000, 24'hFFFFFF, 24'd0);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1, 10'd0);
        send_pixel(10'd2, 10'd0);
        send_pixel(10'd3, 10'd0);
        wait_drain();
        set_gradient(24'd144, 24'd168, 24'd0, 24'hFF0000, 24'd0,
                     24'h000000, 24'hFFFFFF, 24'd15);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd15, 10'd0);
        send_pixel(10'd30, 10'd15);
        send_pixel(10'd1023, 10'd1023);
    endtask

    // direction past unit length, full scale, and pixels well outside a frame one pixel wide
    task automatic test_direction_limits();
        wait_drain();
        set_gradient(24'd1, 24'h0007FF, 24'h020000, 24'h01FFFF, 24'hFFFFFF,
                     24'h123456, 24'hFEDCBA, 24'd1);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd512, 10'd1023);
    endtask

    task automatic test_random_gradients();
        int          w, h, dx, dy, stp, ew, eh;
        logic [23:0] sc;
        logic [9:0]  px, py;
        for (int ph = 0; ph < 10; ph++) begin
            w  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 1024);
            h  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 1024);
            dx = $urandom_range(0, 131072) - 65536;
            dy = $urandom_range(0, 131072) - 65536;
            if ($urandom_range(0, 5) == 0) begin
                dx = $urandom_range(0, 262143) - 131072;
                dy = $urandom_range(0, 262143) - 131072;
            end
            case ($urandom_range(0, 9))
                0:       sc = 24'd0;
                1:       sc = 24'($urandom);
                default: sc = 24'($urandom_range(16, 4096));
            endcase
            stp = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            wait_drain();
            // upper data bits are junk the block must drop
            set_gradient({13'($urandom), 11'(w)}, {13'($urandom), 11'(h)},
                         {6'($urandom), 18'(dx)}, {6'($urandom), 18'(dy)}, sc,
                         24'($urandom), 24'($urandom), {20'($urandom), 4'(stp)});
            ew = (w == 0) ? 1 : ((w > 1024) ? 1024 : w);
            eh = (h == 0) ? 1 : ((h > 1024) ? 1024 : h);
            for (int n = 0; n < 55; n++) begin
                if ($urandom_range(0, 7) == 0) begin
                    px = 10'($urandom);
                    py = 10'($urandom);
                end else begin
                    px = 10'($urandom_range(0, ew - 1));
                    py = 10'($urandom_range(0, eh - 1));
                end
                send_pixel(px, py);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_color_extremes();
        test_dither_and_step();
        test_direction_limits();
        test_random_gradients();
        wait_drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pixel_want_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
